// File: rtl/core/s20_pkg.sv
// Shared types, constants and functions of the Salsa20 stream cipher.
// Depends on nothing; every other file of the block uses it.
package s20_pkg;

    localparam logic [31:0] SIGMA0     = 32'h6170_7865;
    localparam logic [31:0] SIGMA1_256 = 32'h3320_646E;
    localparam logic [31:0] SIGMA2_256 = 32'h7962_2D32;
    localparam logic [31:0] SIGMA1_128 = 32'h3120_646E;
    localparam logic [31:0] SIGMA2_128 = 32'h7962_2D36;
    localparam logic [31:0] SIGMA3     = 32'h6B20_6574;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DROUNDS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE  = 3'd6;

    localparam logic [3:0] DROUNDS_RESET  = 4'd10;
    localparam logic       KEY_MODE_RESET = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 2;

    // Word indices a, b, c, d of the four quarter rounds: column round, then row round.
    localparam logic [3:0] QR_IDX [0:1][0:3][0:3] = '{
        '{'{4'd0,  4'd4,  4'd8,  4'd12}, '{4'd5,  4'd9,  4'd13, 4'd1},
          '{4'd10, 4'd14, 4'd2,  4'd6},  '{4'd15, 4'd3,  4'd7,  4'd11}},
        '{'{4'd0,  4'd1,  4'd2,  4'd3},  '{4'd5,  4'd6,  4'd7,  4'd4},
          '{4'd10, 4'd11, 4'd8,  4'd9},  '{4'd15, 4'd12, 4'd13, 4'd14}}
    };

    typedef logic [15:0][31:0] t_block;

    typedef struct packed {
        logic [63:0] key_0_7;
        logic [63:0] key_8_15;
        logic [63:0] key_16_23;
        logic [63:0] key_24_31;
        logic [63:0] nonce;
        logic [3:0]  drounds;
        logic        key_mode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic        restart;
        logic        keep_cur;
        logic        restart_slot;
        logic [63:0] restart_cnt;
        logic        consume;
        logic        rd_slot;
        logic [3:0]  rd_word;
    } t_ks_ctl;

    function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic t_block make_init(t_cfg cfg, logic [63:0] cnt);
        t_block w;
        w[0]  = SIGMA0;
        w[1]  = cfg.key_0_7[31:0];
        w[2]  = cfg.key_0_7[63:32];
        w[3]  = cfg.key_8_15[31:0];
        w[4]  = cfg.key_8_15[63:32];
        w[6]  = cfg.nonce[31:0];
        w[7]  = cfg.nonce[63:32];
        w[8]  = cnt[31:0];
        w[9]  = cnt[63:32];
        w[15] = SIGMA3;
        if (cfg.key_mode) begin
            w[5]  = SIGMA1_256;
            w[10] = SIGMA2_256;
            w[11] = cfg.key_16_23[31:0];
            w[12] = cfg.key_16_23[63:32];
            w[13] = cfg.key_24_31[31:0];
            w[14] = cfg.key_24_31[63:32];
        end else begin
            w[5]  = SIGMA1_128;
            w[10] = SIGMA2_128;
            w[11] = cfg.key_0_7[31:0];
            w[12] = cfg.key_0_7[63:32];
            w[13] = cfg.key_8_15[31:0];
            w[14] = cfg.key_8_15[63:32];
        end
        return w;
    endfunction

endpackage

// File: rtl/core/s20_front.sv
// Input queue of the Salsa20 stream cipher: holds accepted message bytes for the back end.
// Depends on s20_pkg.
module s20_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  s20_pkg::t_item i_item,
    output logic           o_head_valid,
    output s20_pkg::t_item o_head,
    input  logic           i_pop
);

    localparam int unsigned PTR_W = $clog2(s20_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(s20_pkg::QUEUE_DEPTH + 1);

    s20_pkg::t_item       r_mem [s20_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;
    logic [CNT_W-1:0]     r_count;
    logic                 push;
    logic                 pop;

    assign o_in_ready   = (r_count != CNT_W'(s20_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_head];
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_mem[r_tail] <= i_item;
                r_tail        <= r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/s20_keygen.sv
// Keystream generator of the Salsa20 stream cipher: round engine and two block buffers.
// Depends on s20_pkg.
module s20_keygen (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  s20_pkg::t_cfg    i_cfg,
    input  s20_pkg::t_ks_ctl i_ctl,
    output logic             o_rd_valid,
    output logic [31:0]      o_rd_data
);

    typedef enum logic [1:0] {
        G_IDLE,
        G_ROUND,
        G_ADD
    } t_gstate;

    t_gstate          r_state;
    s20_pkg::t_block  r_work;
    s20_pkg::t_block  r_slot [2];
    logic [1:0]       r_valid;
    logic             r_wptr;
    logic [63:0]      r_cnt;
    logic [3:0]       r_dr;
    logic [1:0]       r_phase;
    s20_pkg::t_block  init;
    s20_pkg::t_block  n_step;
    s20_pkg::t_block  n_sum;
    logic [1:0]       n_valid;

    assign init       = s20_pkg::make_init(i_cfg, r_cnt);
    assign o_rd_valid = r_valid[i_ctl.rd_slot];
    assign o_rd_data  = r_slot[i_ctl.rd_slot][i_ctl.rd_word];

    // Each cycle does half of a column or row round: two of the four steps of every quarter.
    always_comb begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] x;
        logic [31:0] y;
        n_step = r_work;
        for (int q = 0; q < 4; q++) begin
            a = r_work[s20_pkg::QR_IDX[r_phase[1]][q][0]];
            b = r_work[s20_pkg::QR_IDX[r_phase[1]][q][1]];
            c = r_work[s20_pkg::QR_IDX[r_phase[1]][q][2]];
            d = r_work[s20_pkg::QR_IDX[r_phase[1]][q][3]];
            if (!r_phase[0]) begin
                x = b ^ s20_pkg::rotl(a + d, 7);
                y = c ^ s20_pkg::rotl(x + a, 9);
                n_step[s20_pkg::QR_IDX[r_phase[1]][q][1]] = x;
                n_step[s20_pkg::QR_IDX[r_phase[1]][q][2]] = y;
            end else begin
                x = d ^ s20_pkg::rotl(c + b, 13);
                y = a ^ s20_pkg::rotl(x + c, 18);
                n_step[s20_pkg::QR_IDX[r_phase[1]][q][3]] = x;
                n_step[s20_pkg::QR_IDX[r_phase[1]][q][0]] = y;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_sum[i] = r_work[i] + init[i];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.restart) begin
            n_valid = '0;
            if (i_ctl.keep_cur) begin
                n_valid[i_ctl.rd_slot] = 1'b1;
            end
        end else begin
            if (i_ctl.consume) begin
                n_valid[i_ctl.rd_slot] = 1'b0;
            end
            if (r_state == G_ADD) begin
                n_valid[r_wptr] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_valid <= '0;
            r_wptr  <= 1'b0;
            r_cnt   <= '0;
            r_dr    <= '0;
            r_phase <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.restart) begin
                r_state <= G_IDLE;
                r_wptr  <= i_ctl.restart_slot;
                r_cnt   <= i_ctl.restart_cnt;
            end else begin
                unique case (r_state)
                    G_IDLE: begin
                        if (!r_valid[r_wptr]) begin
                            r_work  <= init;
                            r_dr    <= i_cfg.drounds;
                            r_phase <= '0;
                            r_state <= (i_cfg.drounds == '0) ? G_ADD : G_ROUND;
                        end
                    end
                    G_ROUND: begin
                        r_work  <= n_step;
                        r_phase <= r_phase + 1'b1;
                        if (r_phase == 2'd3) begin
                            r_dr <= r_dr - 1'b1;
                            if (r_dr == 4'd1) begin
                                r_state <= G_ADD;
                            end
                        end
                    end
                    G_ADD: begin
                        r_slot[r_wptr] <= n_sum;
                        r_wptr         <= r_wptr + 1'b1;
                        r_cnt          <= r_cnt + 64'd1;
                        r_state        <= G_IDLE;
                    end
                    default: begin
                        r_state <= G_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/core/salsa20_stream_cipher.sv
// Salsa20 stream cipher top level: configuration registers, input queue, keystream
// generator and the byte XOR back end with its output register. Depends on s20_pkg,
// s20_front and s20_keygen.
// Within a message one byte per cycle while keystream is ready and the output is not
// stalled; the next keystream block is made while the current one is in use. A message
// end or a register write restarts the generator, so the first byte of the next message
// waits for a new block. A byte whose block is ready passes through the queue and the
// output register.
// Reset is synchronous and active low; it restores the register defaults and empties the block.
module salsa20_stream_cipher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [s20_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_msg_byte,
    input  logic                           i_msg_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_out_last
);

    s20_pkg::t_cfg    r_cfg;
    s20_pkg::t_item   in_item;
    s20_pkg::t_item   head;
    s20_pkg::t_ks_ctl ks_ctl;
    logic             head_valid;
    logic             ks_valid;
    logic [31:0]      ks_word;
    logic             cfg_fire;
    logic             fire;
    logic             keep_cur;
    logic [5:0]       r_off;
    logic             r_rptr;
    logic [63:0]      r_cons_cnt;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    assign o_cfg_ready  = 1'b1;
    assign cfg_fire     = i_cfg_valid;
    assign in_item.data = i_msg_byte;
    assign in_item.last = i_msg_last;

    s20_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (in_item),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (fire)
    );

    assign fire     = head_valid && ks_valid && (!r_out_valid || i_out_ready);
    assign keep_cur = (r_off != '0);

    // A message end restarts the keystream at block zero; a register write discards blocks made
    // ahead, and keeps the block in use only if some of its bytes have been used already.
    always_comb begin
        ks_ctl.rd_slot  = r_rptr;
        ks_ctl.rd_word  = r_off[5:2];
        ks_ctl.consume  = fire && !head.last && (r_off == 6'd63);
        ks_ctl.restart  = (fire && head.last) || cfg_fire;
        if (fire && head.last) begin
            ks_ctl.keep_cur     = 1'b0;
            ks_ctl.restart_slot = r_rptr;
            ks_ctl.restart_cnt  = '0;
        end else begin
            ks_ctl.keep_cur     = keep_cur;
            ks_ctl.restart_slot = r_rptr + keep_cur;
            ks_ctl.restart_cnt  = r_cons_cnt + {63'd0, keep_cur};
        end
    end

    s20_keygen u_keygen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ctl      (ks_ctl),
        .o_rd_valid (ks_valid),
        .o_rd_data  (ks_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{key_0_7:   64'd0,
                       key_8_15:  64'd0,
                       key_16_23: 64'd0,
                       key_24_31: 64'd0,
                       nonce:     64'd0,
                       drounds:   s20_pkg::DROUNDS_RESET,
                       key_mode:  s20_pkg::KEY_MODE_RESET};
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                s20_pkg::CFG_KEY_0_7:   r_cfg.key_0_7   <= i_cfg_data;
                s20_pkg::CFG_KEY_8_15:  r_cfg.key_8_15  <= i_cfg_data;
                s20_pkg::CFG_KEY_16_23: r_cfg.key_16_23 <= i_cfg_data;
                s20_pkg::CFG_KEY_24_31: r_cfg.key_24_31 <= i_cfg_data;
                s20_pkg::CFG_NONCE:     r_cfg.nonce     <= i_cfg_data;
                s20_pkg::CFG_DROUNDS:   r_cfg.drounds   <= i_cfg_data[3:0];
                s20_pkg::CFG_KEY_MODE:  r_cfg.key_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off       <= '0;
            r_rptr      <= 1'b0;
            r_cons_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= head.data ^ ks_word[{r_off[1:0], 3'b000} +: 8];
                r_out_last  <= head.last;
                if (head.last) begin
                    r_off      <= '0;
                    r_cons_cnt <= '0;
                end else begin
                    r_off <= r_off + 1'b1;
                    if (r_off == 6'd63) begin
                        r_rptr     <= r_rptr + 1'b1;
                        r_cons_cnt <= r_cons_cnt + 64'd1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule
